@@ src/atfp_pkg.sv @@
// ----------------------------------------------------------------------------
// atfp_pkg: shared types and constants for the tagged frame parser
// Configuration defaults, result kinds, frame length limit and the
// structs that pass between the top level and the parse core.
// ----------------------------------------------------------------------------
package atfp_pkg;

	// Longest frame in bytes before it is dropped
	localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_ANGLE_LIMIT = 2'd0;
	localparam logic [1:0] REG_POS_LIMIT   = 2'd1;
	localparam logic [1:0] REG_ANGLE_CTR   = 2'd2;
	localparam logic [1:0] REG_POS_CTR     = 2'd3;

	// Reset values of the registers
	localparam logic [9:0]  ANGLE_LIMIT_RST = 10'd180;
	localparam logic [10:0] POS_LIMIT_RST   = 11'd640;
	localparam logic [9:0]  ANGLE_CTR_RST   = 10'd90;
	localparam logic [10:0] POS_CTR_RST     = 11'd320;

	// Result kinds
	localparam logic [1:0] KIND_MOVE     = 2'd0;
	localparam logic [1:0] KIND_RANGE    = 2'd1;
	localparam logic [1:0] KIND_NO_MOVE  = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	// Frame delimiters and tags
	localparam logic [7:0] CH_START  = 8'h23;
	localparam logic [7:0] CH_END    = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] TAG_ANGLE = 8'h61;
	localparam logic [7:0] TAG_POS   = 8'h78;
	localparam logic [7:0] TAG_COL   = 8'h63;
	localparam logic [7:0] TAG_CMD   = 8'h66;

	typedef struct packed {
		logic [9:0]  angle_limit;
		logic [10:0] position_limit;
		logic [9:0]  angle_center;
		logic [10:0] position_center;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         kind;
		logic signed [10:0] angle_offset;
		logic signed [11:0] position_offset;
		logic [3:0]         colour_code;
		logic [3:0]         command_code;
		logic               hold_set;
	} result_t;

endpackage

@@ src/ascii_tagged_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_tagged_frame_parser: parser for '#'...'$' tagged command frames
// Input stage, parse core, result register and configuration registers.
// ----------------------------------------------------------------------------
// One received byte per beat; a byte can be accepted on every clock while
// the block does not stall. Each byte is held in the input register, the
// parse core updates its state from it and, on a frame end or an overlong
// frame, loads one result into the output register. The result register
// and the input register let a new byte enter while a result waits; the
// block only stalls when a byte with a result meets a full result register
// that is not being taken. Configuration registers are written directly
// and take effect on the next byte.
module ascii_tagged_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] external_hold, [15:9] zero
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [10:0] angle_offset, [22:11] position_offset,
	                               // [26:23] colour_code, [30:27] command_code,
	                               // [31] hold_set
	output logic [1:0]  m_tuser,   // [1:0] kind
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	atfp_pkg::cfg_t    cfg_q;
	atfp_pkg::result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       hold_s1;
	logic       step;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_data_q;

	// Stage 1 byte advances unless its result would overrun a waiting one
	assign step     = valid_s1 && (!res.valid || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_limit     <= atfp_pkg::ANGLE_LIMIT_RST;
			cfg_q.position_limit  <= atfp_pkg::POS_LIMIT_RST;
			cfg_q.angle_center    <= atfp_pkg::ANGLE_CTR_RST;
			cfg_q.position_center <= atfp_pkg::POS_CTR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				atfp_pkg::REG_ANGLE_LIMIT: cfg_q.angle_limit     <= cfg_data[9:0];
				atfp_pkg::REG_POS_LIMIT:   cfg_q.position_limit  <= cfg_data;
				atfp_pkg::REG_ANGLE_CTR:   cfg_q.angle_center    <= cfg_data[9:0];
				atfp_pkg::REG_POS_CTR:     cfg_q.position_center <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			hold_s1 <= s_tdata[8];
		end
	end

	atfp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (byte_s1),
		.external_hold (hold_s1),
		.cfg           (cfg_q),
		.result        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && res.valid)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_kind_q <= res.kind;
			out_data_q <= {res.hold_set, res.command_code, res.colour_code,
			               res.position_offset, res.angle_offset};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

endmodule

@@ src/atfp_core.sv @@
// ----------------------------------------------------------------------------
// atfp_core: parse state and per-byte step logic
// Holds the frame state and works out, for the byte in the input stage,
// the next state and the result beat it causes (if any).
// ----------------------------------------------------------------------------
module atfp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,          // byte in stage 1 is consumed
	input  logic [7:0]        rx_byte,
	input  logic              external_hold,
	input  atfp_pkg::cfg_t    cfg,
	output atfp_pkg::result_t result         // combinational, for stage 1 byte
);

	// Parse modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_FRAME  = 3'd1;
	localparam logic [2:0] MODE_ANGLE  = 3'd4;
	localparam logic [2:0] MODE_POS    = 3'd5;
	localparam logic [2:0] MODE_COLOUR = 3'd6;
	localparam logic [2:0] MODE_CMD    = 3'd7;

	localparam logic signed [20:0] ACC_SAT = 21'sd65535;

	logic [2:0]         mode_q,    mode_n;
	logic [7:0]         count_q,   count_n;
	logic signed [16:0] angle_q,   angle_n;
	logic signed [16:0] pos_q,     pos_n;
	logic [3:0]         colour_q,  colour_n;
	logic [3:0]         cmd_q,     cmd_n;
	logic               a_seen_q,  a_seen_n;
	logic               p_seen_q,  p_seen_n;

	logic               is_digit;
	logic [3:0]         digit;
	logic signed [16:0] aoff, poff;
	logic               hold;

	// Decimal shift-add with saturation at 65535
	function automatic logic signed [16:0] acc_digit(input logic signed [16:0] acc,
		input logic [3:0] d);
		logic signed [20:0] ext;
		logic signed [20:0] v;
		ext = {{4{acc[16]}}, acc};
		v   = (ext <<< 3) + (ext <<< 1) + $signed({17'd0, d});
		if (v > ACC_SAT)
			return ACC_SAT[16:0];
		return v[16:0];
	endfunction

	assign is_digit = (rx_byte >= atfp_pkg::CH_ZERO) && (rx_byte <= atfp_pkg::CH_NINE);
	assign digit    = rx_byte[3:0];
	assign aoff     = angle_q - $signed({7'd0, cfg.angle_center});
	assign poff     = pos_q - $signed({6'd0, cfg.position_center});

	// Next state and result for one byte
	always_comb begin
		mode_n   = mode_q;
		count_n  = count_q;
		angle_n  = angle_q;
		pos_n    = pos_q;
		colour_n = colour_q;
		cmd_n    = cmd_q;
		a_seen_n = a_seen_q;
		p_seen_n = p_seen_q;
		hold     = 1'b0;

		result                 = '0;
		result.kind            = atfp_pkg::KIND_NO_MOVE;

		if (count_q >= atfp_pkg::MAX_FRAME_BYTES) begin
			// overlong frame: drop the byte and report
			count_n      = '0;
			mode_n       = MODE_IDLE;
			result.valid = 1'b1;
			result.kind  = atfp_pkg::KIND_OVERFLOW;
		end else begin
			count_n = count_q + 8'd1;
			if (rx_byte == atfp_pkg::CH_START) begin
				count_n  = 8'd1;
				a_seen_n = 1'b0;
				p_seen_n = 1'b0;
				mode_n   = MODE_FRAME;
			end else if (rx_byte == atfp_pkg::CH_END && mode_q != MODE_IDLE) begin
				mode_n          = MODE_IDLE;
				count_n         = '0;
				result.hold_set = (cmd_q != 4'd0);
				hold            = external_hold || (cmd_q != 4'd0);
				result.valid    = 1'b1;
				if (angle_q > $signed({7'd0, cfg.angle_limit}) ||
				    pos_q > $signed({6'd0, cfg.position_limit})) begin
					result.kind = atfp_pkg::KIND_RANGE;
					a_seen_n    = 1'b0;
					p_seen_n    = 1'b0;
					angle_n     = '0;
					pos_n       = '0;
				end else if (a_seen_q && p_seen_q && !hold) begin
					result.kind            = atfp_pkg::KIND_MOVE;
					result.angle_offset    = aoff[10:0];
					result.position_offset = poff[11:0];
					angle_n  = aoff;
					pos_n    = poff;
					a_seen_n = 1'b0;
					p_seen_n = 1'b0;
				end else begin
					result.kind = atfp_pkg::KIND_NO_MOVE;
				end
			end else if (rx_byte == atfp_pkg::CH_END) begin
				// stray end mark
				mode_n  = MODE_IDLE;
				pos_n   = '0;
				count_n = '0;
			end else if (mode_q == MODE_IDLE) begin
				count_n = '0;
			end

			// a non-digit closes the open field
			if (!is_digit && mode_n[2])
				mode_n = MODE_FRAME;

			// field digit
			case (mode_n)
				MODE_ANGLE:  angle_n  = acc_digit(angle_n, digit);
				MODE_POS:    pos_n    = acc_digit(pos_n, digit);
				MODE_COLOUR: colour_n = digit;
				MODE_CMD: begin
					if (!external_hold)
						cmd_n = digit;
				end
				default: ;
			endcase

			// tags open a new field
			if (mode_n != MODE_IDLE) begin
				case (rx_byte)
					atfp_pkg::TAG_ANGLE: begin
						mode_n   = MODE_ANGLE;
						a_seen_n = 1'b1;
						angle_n  = '0;
					end
					atfp_pkg::TAG_POS: begin
						mode_n   = MODE_POS;
						p_seen_n = 1'b1;
						pos_n    = '0;
					end
					atfp_pkg::TAG_COL: begin
						mode_n   = MODE_COLOUR;
						colour_n = '0;
					end
					atfp_pkg::TAG_CMD: begin
						mode_n = MODE_CMD;
						cmd_n  = '0;
					end
					default: ;
				endcase
			end
		end

		result.colour_code  = colour_n;
		result.command_code = cmd_n;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			count_q  <= '0;
			angle_q  <= '0;
			pos_q    <= '0;
			colour_q <= '0;
			cmd_q    <= '0;
			a_seen_q <= 1'b0;
			p_seen_q <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_n;
			count_q  <= count_n;
			angle_q  <= angle_n;
			pos_q    <= pos_n;
			colour_q <= colour_n;
			cmd_q    <= cmd_n;
			a_seen_q <= a_seen_n;
			p_seen_q <= p_seen_n;
		end
	end

endmodule
